FILE: hdl/windowed_ipc_quota_controller_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the windowed IPC quota controller
// Concurrent checks that reduce to nothing when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_IPC_QUOTA_CONTROLLER_CORE_ASSERT_SVH
`define WINDOWED_IPC_QUOTA_CONTROLLER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WIQC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define WIQC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WIQC_ASSERT(lbl, clk, rstn, prop, msg)
`define WIQC_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

FILE: hdl/wiqc_pkg.sv
// ----------------------------------------------------------------------------
// wiqc_pkg
// Shared constants of the windowed IPC quota controller.
// ----------------------------------------------------------------------------
package wiqc_pkg;
  localparam int WindowMaxDefault  = 256;
  localparam int SampleBitsDefault = 16;
  localparam int QuotaBits         = 19;
  localparam int GainBits          = 16;
  localparam int GainFrac          = 14;
  localparam int WinLenBits        = 9;
  localparam int CfgDataBits       = 19;

  localparam logic [1:0] CfgWinLen   = 2'd0;
  localparam logic [1:0] CfgMinQuota = 2'd1;
  localparam logic [1:0] CfgMaxQuota = 2'd2;
  localparam logic [1:0] CfgGain     = 2'd3;

  localparam logic [1:0] ActNone    = 2'd0;
  localparam logic [1:0] ActRaise   = 2'd1;
  localparam logic [1:0] ActCutHigh = 2'd2;
  localparam logic [1:0] ActCutLow  = 2'd3;

  localparam logic [WinLenBits-1:0] WinLenReset = 9'd16;
  localparam logic [QuotaBits-1:0]  MinQuotaReset = 19'd5000;
  localparam logic [QuotaBits-1:0]  MaxQuotaReset = 19'd400000;
  localparam logic [GainBits-1:0]   GainReset = 16'd18022;
endpackage

FILE: hdl/wiqc_divider.sv
// ----------------------------------------------------------------------------
// wiqc_divider
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wiqc_divider #(
  parameter int NumBits = 40,
  parameter int DenBits = 13
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  output logic               busy_o,
  output logic [NumBits-1:0] quo_o
);
  localparam int CntBits = $clog2(NumBits + 1);
  logic [NumBits-1:0] quo_q, quo_d;
  logic [DenBits:0]   rem_q, rem_d;
  logic [DenBits-1:0] den_q, den_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [DenBits:0]   trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    trial = {rem_q[DenBits-1:0], quo_q[NumBits-1]};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = CntBits'(NumBits);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;
endmodule

FILE: hdl/wiqc_sqrt.sv
// ----------------------------------------------------------------------------
// wiqc_sqrt
// Digit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module wiqc_sqrt #(
  parameter int RadBits = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [RadBits-1:0] rad_i,
  output logic               busy_o,
  output logic [RadBits/2-1:0] root_o
);
  localparam int RootBits = RadBits / 2;
  localparam int CntBits  = $clog2(RootBits + 1);
  logic [RadBits-1:0]  rad_q, rad_d;
  logic [RootBits+1:0] rem_q, rem_d;
  logic [RootBits-1:0] root_q, root_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [RootBits+1:0] trial, rsh;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    rsh    = {rem_q[RootBits-1:0], rad_q[RadBits-1:RadBits-2]};
    trial  = {root_q, 2'b01};
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntBits'(RootBits);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      rad_d = {rad_q[RadBits-3:0], 2'b00};
      if (rsh >= trial) begin
        rem_d  = rsh - trial;
        root_d = {root_q[RootBits-2:0], 1'b1};
      end else begin
        rem_d  = rsh;
        root_d = {root_q[RootBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = (cnt_q != '0);
  assign root_o = root_q;
endmodule

FILE: hdl/wiqc_serial_mult.sv
// ----------------------------------------------------------------------------
// wiqc_serial_mult
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module wiqc_serial_mult #(
  parameter int ABits = 19,
  parameter int BBits = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [ABits-1:0]       a_i,
  input  logic [BBits-1:0]       b_i,
  output logic                   busy_o,
  output logic [ABits+BBits-1:0] prod_o
);
  localparam int PBits   = ABits + BBits;
  localparam int CntBits = $clog2(BBits + 1);
  logic [PBits-1:0]   acc_q, acc_d;
  logic [ABits-1:0]   a_q, a_d;
  logic [BBits-1:0]   b_q, b_d;
  logic [CntBits-1:0] cnt_q, cnt_d;

  always_comb begin
    acc_d = acc_q;
    a_d   = a_q;
    b_d   = b_q;
    cnt_d = cnt_q;
    if (start_i) begin
      acc_d = '0;
      a_d   = a_i;
      b_d   = b_i;
      cnt_d = CntBits'(BBits);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      b_d   = {b_q[BBits-2:0], 1'b0};
      acc_d = {acc_q[PBits-2:0], 1'b0} +
              (b_q[BBits-1] ? PBits'(a_q) : PBits'(0));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign busy_o = (cnt_q != '0);
  assign prod_o = acc_q;
endmodule

FILE: hdl/windowed_ipc_quota_controller_core.sv
// ----------------------------------------------------------------------------
// Windowed IPC quota controller core
// Sliding-window mean and deviation of IPC samples drive a quota.
//
//   channel  | signals                               | direction
//   in       | in_valid_i/in_ready_o, ipc_sample_i    | request in
//   out      | out_valid_o/out_ready_i, quota_o...    | request out
//   cfg      | cfg_we_i, cfg_idx_i, cfg_data_i        | write only
//
// After a request is taken the core runs three serial multiplies (four with a
// raise), two divides and a square root in turn before out_valid_o rises.
// One request in flight; the next can be taken in the cycle out_valid_o rises.
// A held result stalls the core only when the next result is ready.
// Reset clears all control state; the sample ring needs no clearing.
// ----------------------------------------------------------------------------
`include "windowed_ipc_quota_controller_core_assert.svh"
module windowed_ipc_quota_controller_core #(
  parameter int WINDOW_MAX  = wiqc_pkg::WindowMaxDefault,
  parameter int SAMPLE_BITS = wiqc_pkg::SampleBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [SAMPLE_BITS-1:0]            ipc_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [wiqc_pkg::QuotaBits-1:0]    quota_o,
  output logic [1:0]                        action_o,
  output logic                              refilling_o,
  output logic [SAMPLE_BITS-1:0]            window_mean_o,
  output logic [SAMPLE_BITS-1:0]            window_std_o,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [wiqc_pkg::CfgDataBits-1:0]  cfg_data_i
);
  localparam int SB    = SAMPLE_BITS;
  localparam int AW    = $clog2(WINDOW_MAX);
  localparam int NB    = $clog2(WINDOW_MAX + 1);
  localparam int SumB  = SB + NB;
  localparam int SqB   = 2 * SB + NB;
  localparam int QB    = wiqc_pkg::QuotaBits;
  localparam int GB    = wiqc_pkg::GainBits;
  localparam int BB    = SB + 2;
  localparam int WLB   = wiqc_pkg::WinLenBits;
  localparam int MA    = (QB > SB) ? QB : SB;
  localparam int MB    = (GB > SB) ? GB : SB;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRead  = 4'd1;
  localparam logic [3:0] StSqOld = 4'd2;
  localparam logic [3:0] StSqNew = 4'd3;
  localparam logic [3:0] StSums  = 4'd4;
  localparam logic [3:0] StDivS  = 4'd5;
  localparam logic [3:0] StDivQ  = 4'd6;
  localparam logic [3:0] StMm    = 4'd7;
  localparam logic [3:0] StSqrt  = 4'd8;
  localparam logic [3:0] StFin   = 4'd9;
  localparam logic [3:0] StRaise = 4'd10;
  localparam logic [3:0] StDone  = 4'd11;

  // configuration
  logic [WLB-1:0] win_len_q;
  logic [QB-1:0]  min_q_q, max_q_q;
  logic [GB-1:0]  gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= wiqc_pkg::WinLenReset;
      min_q_q   <= wiqc_pkg::MinQuotaReset;
      max_q_q   <= wiqc_pkg::MaxQuotaReset;
      gain_q    <= wiqc_pkg::GainReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wiqc_pkg::CfgWinLen:   win_len_q <= cfg_data_i[WLB-1:0];
        wiqc_pkg::CfgMinQuota: min_q_q   <= cfg_data_i[QB-1:0];
        wiqc_pkg::CfgMaxQuota: max_q_q   <= cfg_data_i[QB-1:0];
        wiqc_pkg::CfgGain:     gain_q    <= cfg_data_i[GB-1:0];
        default: ;
      endcase
    end
  end

  logic [NB-1:0] eff_len;
  always_comb begin
    if (win_len_q == '0) begin
      eff_len = NB'(1);
    end else if (32'(win_len_q) > WINDOW_MAX) begin
      eff_len = NB'(WINDOW_MAX);
    end else begin
      eff_len = NB'(win_len_q);
    end
  end

  // state
  logic [SB-1:0]   ring [WINDOW_MAX];
  logic [AW-1:0]   head_q;
  logic [NB-1:0]   fill_q;
  logic [SumB-1:0] sum_q;
  logic [SqB-1:0]  sumsq_q;
  logic [SB-1:0]   mean_q, std_q;
  logic [BB-1:0]   top_q, rbnd_q, low_q;
  logic [QB-1:0]   quota_q;
  logic            refill_q;
  logic [3:0]      st_q;
  logic [SB-1:0]   smp_q, old_q, rd_q;
  logic [2*SB-1:0] oldsq_q;
  logic [1:0]      act_q;
  logic            slide_q;
  logic [SB-1:0]   mean_n_q;
  logic            ovalid_q;
  logic [QB-1:0]   out_quota_q;
  logic [1:0]      out_act_q;
  logic            out_refill_q;
  logic [SB-1:0]   out_mean_q, out_std_q;

  // serial units; the multiplier and divider are shared between steps
  logic             mul_start, mul_busy, div_start, div_busy, sqr_start, sqr_busy;
  logic [MA-1:0]    mul_a;
  logic [MB-1:0]    mul_b;
  logic [MA+MB-1:0] mul_p;
  logic [SqB-1:0]   div_num, div_quo;
  logic [2*SB-1:0]  sqrt_rad;
  logic [SB-1:0]    sqrt_root;

  wiqc_serial_mult #(.ABits(MA), .BBits(MB)) u_mult (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .busy_o(mul_busy), .prod_o(mul_p)
  );
  wiqc_divider #(.NumBits(SqB), .DenBits(NB)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(fill_q),
    .busy_o(div_busy), .quo_o(div_quo)
  );
  wiqc_sqrt #(.RadBits(2 * SB)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sqr_start), .rad_i(sqrt_rad),
    .busy_o(sqr_busy), .root_o(sqrt_root)
  );

  logic           accept, go_wait, upd_win, cut_now, load_out, out_wait;
  logic [AW-1:0]  old_idx, head_nxt;
  logic [NB:0]    old_sum;
  logic [BB-1:0]  s_ext;
  logic [SqB-1:0] msq_q, var_w;
  logic [SB-1:0]  old_sel;
  logic [1:0]     act_in;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (st_q == StIdle);
  assign old_sum    = (NB+1)'(head_q) + (NB+1)'(WINDOW_MAX) - (NB+1)'(fill_q);
  assign old_idx    = (old_sum >= (NB+1)'(WINDOW_MAX)) ?
                      AW'(old_sum - (NB+1)'(WINDOW_MAX)) : AW'(old_sum);
  assign head_nxt   = (32'(head_q) == WINDOW_MAX - 1) ? '0 : head_q + 1'b1;
  assign s_ext      = BB'(ipc_sample_i);
  assign upd_win    = slide_q || (32'(fill_q) < WINDOW_MAX);
  assign cut_now    = (act_q == wiqc_pkg::ActCutHigh) || (act_q == wiqc_pkg::ActCutLow);
  assign old_sel    = (slide_q && !cut_now) ? rd_q : '0;

  always_comb begin
    act_in = wiqc_pkg::ActNone;
    if (!refill_q) begin
      if (s_ext > top_q) begin
        act_in = wiqc_pkg::ActCutHigh;
      end else if ($signed(s_ext) >= $signed(rbnd_q)) begin
        act_in = wiqc_pkg::ActRaise;
      end else if ($signed(s_ext) < $signed(low_q)) begin
        act_in = wiqc_pkg::ActCutLow;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= ring[old_idx];
    end
    if (st_q == StSqNew && !go_wait && upd_win) begin
      ring[head_q] <= smp_q;
    end
  end

  assign var_w = (msq_q > SqB'(mul_p)) ? msq_q - SqB'(mul_p) : '0;
  assign go_wait = mul_busy || div_busy || sqr_busy;

  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    sqr_start = 1'b0;
    mul_a    = MA'(old_sel);
    mul_b    = MB'(old_sel);
    div_num  = SqB'(sum_q);
    sqrt_rad = var_w[2*SB-1:0];
    unique case (st_q)
      StRead:  mul_start = 1'b1;
      StSqOld: begin
        mul_a = MA'(smp_q);
        mul_b = MB'(smp_q);
        mul_start = !go_wait;
      end
      StSums:  div_start = 1'b1;
      StDivS:  begin
        div_num = sumsq_q;
        div_start = !go_wait;
      end
      StDivQ:  begin
        mul_a = MA'(mean_n_q);
        mul_b = MB'(mean_n_q);
        mul_start = !go_wait;
      end
      StMm:    sqr_start = !go_wait;
      StFin:   begin
        mul_a = MA'(quota_q);
        mul_b = MB'(gain_q);
        mul_start = (act_q == wiqc_pkg::ActRaise);
      end
      default: ;
    endcase
  end

  logic [SqB-1:0] mean_full;
  assign mean_full = div_quo;

  logic [MA+MB-1:0] raised;
  assign raised = mul_p >> wiqc_pkg::GainFrac;

  assign load_out = (st_q == StDone) && (!ovalid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      head_q   <= '0;
      fill_q   <= '0;
      sum_q    <= '0;
      sumsq_q  <= '0;
      mean_q   <= '0;
      std_q    <= '0;
      top_q    <= '0;
      rbnd_q   <= '0;
      low_q    <= '0;
      quota_q  <= wiqc_pkg::MinQuotaReset;
      refill_q <= 1'b1;
      act_q    <= wiqc_pkg::ActNone;
      slide_q  <= 1'b0;
      smp_q    <= '0;
      old_q    <= '0;
      oldsq_q  <= '0;
      mean_n_q <= '0;
      msq_q    <= '0;
    end else begin
      unique case (st_q)
        StIdle: if (accept) begin
          smp_q   <= ipc_sample_i;
          act_q   <= act_in;
          slide_q <= !refill_q;
          st_q    <= StRead;
        end
        StRead: begin
          if (cut_now) begin
            quota_q  <= min_q_q;
            refill_q <= 1'b1;
            slide_q  <= 1'b0;
            fill_q   <= '0;
            head_q   <= '0;
            sum_q    <= '0;
            sumsq_q  <= '0;
          end
          old_q <= old_sel;
          st_q  <= StSqOld;
        end
        StSqOld: if (!go_wait) begin
          // start of the new-sample square latches old square now
          oldsq_q <= mul_p[2*SB-1:0];
          st_q    <= StSqNew;
        end
        StSqNew: if (!go_wait) begin
          if (upd_win) begin
            sum_q   <= sum_q - SumB'(old_q) + SumB'(smp_q);
            sumsq_q <= sumsq_q - SqB'(oldsq_q) + SqB'(mul_p[2*SB-1:0]);
            head_q  <= head_nxt;
            if (!slide_q) fill_q <= fill_q + 1'b1;
          end
          st_q <= StSums;
        end
        StSums: st_q <= StDivS;
        StDivS: if (!go_wait) begin
          mean_n_q <= (mean_full > SqB'({SB{1'b1}})) ? {SB{1'b1}} : mean_full[SB-1:0];
          st_q <= StDivQ;
        end
        StDivQ: if (!go_wait) begin
          msq_q <= div_quo;
          st_q  <= StMm;
        end
        StMm: if (!go_wait) begin
          st_q <= StSqrt;
        end
        StSqrt: if (!go_wait) begin
          mean_q <= mean_n_q;
          std_q  <= sqrt_root;
          st_q   <= StFin;
        end
        StFin: begin
          if (refill_q && fill_q >= eff_len) begin
            refill_q <= 1'b0;
            top_q  <= BB'(mean_q) + BB'({std_q, 1'b0});
            rbnd_q <= BB'(mean_q) - BB'(std_q);
            low_q  <= BB'(mean_q) - BB'({std_q, 1'b0});
          end
          st_q <= StRaise;
        end
        StRaise: if (!go_wait) begin
          if (act_q == wiqc_pkg::ActRaise) begin
            quota_q <= (raised < (MA+MB)'(max_q_q)) ? raised[QB-1:0] : max_q_q;
          end
          st_q <= StDone;
        end
        StDone: if (load_out) begin
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q     <= 1'b0;
      out_quota_q  <= '0;
      out_act_q    <= wiqc_pkg::ActNone;
      out_refill_q <= 1'b0;
      out_mean_q   <= '0;
      out_std_q    <= '0;
    end else if (load_out) begin
      ovalid_q     <= 1'b1;
      out_quota_q  <= quota_q;
      out_act_q    <= act_q;
      out_refill_q <= refill_q;
      out_mean_q   <= mean_q;
      out_std_q    <= std_q;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  // the sqrt radicand is msq_q (mean of squares) less the squared mean in mul_p, floored at zero
  assign out_valid_o   = ovalid_q;
  assign quota_o       = out_quota_q;
  assign action_o      = out_act_q;
  assign refilling_o   = out_refill_q;
  assign window_mean_o = out_mean_q;
  assign window_std_o  = out_std_q;
  assign out_wait      = out_valid_o && !out_ready_i;

  `WIQC_ASSERT(a_out_hold, clk_i, rst_ni, out_wait |=> out_valid_o && $stable(quota_o), "lost")
  `WIQC_ASSERT(a_fill_bound, clk_i, rst_ni, (32'(fill_q) <= WINDOW_MAX), "fill count overflow")
  `WIQC_ASSERT(a_ready_idle, clk_i, rst_ni, (accept |=> !in_ready_o), "ready during work")
endmodule
